FILE: sv/mbs_pkg.sv
// shared types, constants and elaboration-time table builders for the
// multiband to srgb pixel unit; no dependencies
package mbs_pkg;

  localparam int SAMPLE_BITS_DEF    = 16;
  localparam int LUT_INDEX_BITS_DEF = 12;

  localparam int NUM_BANDS  = 6;
  localparam int NUM_CH     = 3;
  localparam int COEF_BITS  = 19;
  // column sums of |coef| stay below 2^18, so a channel sum grows by 18 bits
  localparam int SUM_GROWTH = 18;
  localparam int GAIN_BITS  = 16;
  localparam int MODE_BITS  = 2;
  localparam int MASK_BITS  = NUM_BANDS;
  localparam int BYTE_BITS  = 8;
  localparam int DATA_BITS  = 32;
  localparam int PADDR_BITS = 3;

  localparam int MAC_STAGES   = 6;
  localparam int SRCH_STEPS   = 8;
  localparam int LANE_STAGES  = MAC_STAGES + SRCH_STEPS;
  localparam int PIPE_STAGES  = LANE_STAGES + 1;
  localparam int THR_BITS     = 15;
  localparam int THR_DEPTH    = 256;
  localparam int LIN_TAB_BITS = 6;
  localparam int LIN_DEPTH    = 64;

  localparam logic [MODE_BITS-1:0] MODE_KEEP   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_MARK   = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FILL   = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_SPARE  = 2'd3;
  localparam logic [GAIN_BITS-1:0] GAIN_RESET  = 16'd624;
  localparam logic [BYTE_BITS-1:0] BYTE_FULL   = 8'hFF;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_GAIN = 1'b1
  } reg_sel_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] red;
    logic [BYTE_BITS-1:0] green;
    logic [BYTE_BITS-1:0] blue;
    logic                 bad;
  } pix_rgb_t;

  typedef logic [THR_DEPTH-1:0][THR_BITS-1:0]  srgb_thr_t;
  typedef logic [LIN_DEPTH-1:0][BYTE_BITS-1:0] srgb_lin_t;

  // Q1.18 mixing matrix, rows are bands, columns are r, g, b
  localparam logic signed [COEF_BITS-1:0] COEF [NUM_BANDS][NUM_CH] = '{
    '{ 19'sd127,    -19'sd109,   19'sd770   },
    '{ -19'sd20313, 19'sd28495,  19'sd154826 },
    '{ 19'sd4541,   19'sd161151, 19'sd37969 },
    '{ 19'sd149274, 19'sd12001,  -19'sd4489 },
    '{ 19'sd75597,  -19'sd5605,  -19'sd831  },
    '{ 19'sd8438,   -19'sd874,   -19'sd62   }
  };

  // smallest index reaching byte b on the power segment of the curve:
  // idx^5 * 269025^12 >= (1000b + 14025)^12 * 2^(5L), exact in 320 bits
  function automatic srgb_thr_t srgb_thr_table(input int lut_bits);
    srgb_thr_t    tab;
    logic [319:0] k12;
    logic [319:0] rhs;
    logic [319:0] lhs;
    logic [319:0] base;
    logic [319:0] ix;
    int           lo;
    int           hi;
    int           mid;
    tab = '0;
    k12 = 320'd1;
    for (int i = 0; i < 12; i++) k12 = k12 * 320'd269025;
    for (int b = 1; b < THR_DEPTH; b++) begin
      base = 320'(1000 * b + 14025);
      rhs  = 320'd1;
      for (int i = 0; i < 12; i++) rhs = rhs * base;
      rhs = rhs << (5 * lut_bits);
      lo  = 0;
      hi  = 1 << lut_bits;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        ix  = 320'(mid);
        lhs = k12;
        for (int i = 0; i < 5; i++) lhs = lhs * ix;
        if (lhs >= rhs) hi = mid;
        else lo = mid + 1;
      end
      tab[b] = THR_BITS'(lo);
    end
    return tab;
  endfunction

  // linear segment of the curve: floor(3294.6 * idx / 2^L)
  function automatic srgb_lin_t srgb_lin_table(input int lut_bits);
    srgb_lin_t tab;
    tab = '0;
    for (int i = 0; i < LIN_DEPTH; i++) begin
      tab[i] = BYTE_BITS'(((32946 * i) >> lut_bits) / 10);
    end
    return tab;
  endfunction

endpackage

FILE: sv/mbs_check.sv
// pixel validity checks: bad bands, spread, edge slope and inner extrema,
// with the verdict delayed to line up with the color lanes; uses mbs_pkg
module mbs_check import mbs_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic [LANE_STAGES-1:0]        en,
  input  logic signed [SAMPLE_BITS-1:0] band [NUM_BANDS],
  input  logic [MASK_BITS-1:0]          mask,
  output logic [NUM_BANDS-1:0]          keep,
  output logic                          bad
);

  localparam int W5 = SAMPLE_BITS + 3;

  logic [NUM_BANDS-1:0]          bad_band;
  logic                          edge_bad;
  logic                          ext_bad;
  logic signed [SAMPLE_BITS-1:0] lo_pair [3];
  logic signed [SAMPLE_BITS-1:0] hi_pair [3];
  logic signed [SAMPLE_BITS-1:0] lo_q [3];
  logic signed [SAMPLE_BITS-1:0] hi_q [3];
  logic signed [SAMPLE_BITS-1:0] mn_q;
  logic signed [SAMPLE_BITS-1:0] mx_q;
  logic signed [SAMPLE_BITS-1:0] mn_next;
  logic signed [SAMPLE_BITS-1:0] mx_next;
  logic signed [W5-1:0]          mn5;
  logic [LANE_STAGES-1:0]        flag_q;

  always_comb begin
    for (int k = 0; k < NUM_BANDS; k++) begin
      bad_band[k] = band[k][SAMPLE_BITS-1] || (band[k] == '0) || mask[k];
    end
    // bands after the first bad one do not enter the sums
    keep[0] = !bad_band[0];
    for (int k = 1; k < NUM_BANDS; k++) keep[k] = keep[k-1] && !bad_band[k];
    edge_bad = (band[0] > band[1]) || (band[NUM_BANDS-2] > band[NUM_BANDS-1]);
    ext_bad  = 1'b0;
    for (int k = 1; k < NUM_BANDS - 1; k++) begin
      if ((band[k-1] > band[k]) && (band[k] < band[k+1])) ext_bad = 1'b1;
      if ((band[k-1] < band[k]) && (band[k] > band[k+1])) ext_bad = 1'b1;
    end
    for (int p = 0; p < 3; p++) begin
      lo_pair[p] = (band[2*p] < band[2*p+1]) ? band[2*p] : band[2*p+1];
      hi_pair[p] = (band[2*p] > band[2*p+1]) ? band[2*p] : band[2*p+1];
    end
  end

  always_comb begin
    mn_next = (lo_q[0] < lo_q[1]) ? lo_q[0] : lo_q[1];
    if (lo_q[2] < mn_next) mn_next = lo_q[2];
    mx_next = (hi_q[0] > hi_q[1]) ? hi_q[0] : hi_q[1];
    if (hi_q[2] > mx_next) mx_next = hi_q[2];
    mn5 = W5'(mn_q) + (W5'(mn_q) <<< 2);
  end

  // once a band is bad the pixel is bad, so the other verdicts simply or in
  always_ff @(posedge clk) begin
    if (en[0]) begin
      flag_q[0] <= (|bad_band) || edge_bad || ext_bad;
      lo_q      <= lo_pair;
      hi_q      <= hi_pair;
    end
    if (en[1]) begin
      flag_q[1] <= flag_q[0];
      mn_q      <= mn_next;
      mx_q      <= mx_next;
    end
    if (en[2]) begin
      flag_q[2] <= flag_q[1] || (W5'(mx_q) > mn5);
    end
    for (int i = 3; i < LANE_STAGES; i++) begin
      if (en[i]) flag_q[i] <= flag_q[i-1];
    end
  end

  assign bad = flag_q[LANE_STAGES-1];

endmodule

FILE: sv/mbs_lane.sv
// one color channel: band mix, magnitude, gain, index and a pipelined
// threshold search for the srgb byte; uses mbs_pkg tables and coefficients
module mbs_lane import mbs_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int LUT_INDEX_BITS = LUT_INDEX_BITS_DEF,
  parameter int CH             = 0
) (
  input  logic                          clk,
  input  logic [LANE_STAGES-1:0]        en,
  input  logic signed [SAMPLE_BITS-1:0] band [NUM_BANDS],
  input  logic [NUM_BANDS-1:0]          keep,
  input  logic [GAIN_BITS-1:0]          gain,
  output logic [BYTE_BITS-1:0]          code
);

  localparam int SumW     = SAMPLE_BITS + SUM_GROWTH;
  localparam int MagW     = SumW - 1;
  localparam int ScW      = MagW + GAIN_BITS;
  localparam int Shift    = SAMPLE_BITS + 25 - LUT_INDEX_BITS;
  localparam int RawW     = ScW - Shift;
  localparam int IdxW     = LUT_INDEX_BITS + 1;
  localparam int LinLimit = (31308 * (1 << LUT_INDEX_BITS) + 9999999) / 10000000;
  localparam logic [IdxW-1:0] IdxOne = IdxW'(1 << LUT_INDEX_BITS);
  localparam srgb_thr_t Thr = srgb_thr_table(LUT_INDEX_BITS);
  localparam srgb_lin_t Lin = srgb_lin_table(LUT_INDEX_BITS);

  logic signed [SumW-1:0]  prod [NUM_BANDS];
  logic signed [SumW-1:0]  psum [3];
  logic signed [SumW-1:0]  sum;
  logic [MagW-1:0]         mag;
  logic [ScW-1:0]          scaled;
  logic [RawW-1:0]         raw;
  logic [IdxW-1:0]         idx;
  logic [BYTE_BITS-1:0]    acc_q  [SRCH_STEPS];
  logic [IdxW-1:0]         sidx_q [SRCH_STEPS];
  logic                    lin_q  [SRCH_STEPS];
  logic [BYTE_BITS-1:0]    linb_q [SRCH_STEPS];

  assign raw = scaled[ScW-1:Shift];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < NUM_BANDS; k++) begin
        prod[k] <= keep[k] ? SumW'(band[k]) * SumW'(COEF[k][CH]) : '0;
      end
    end
    if (en[1]) begin
      for (int p = 0; p < 3; p++) psum[p] <= prod[2*p] + prod[2*p+1];
    end
    if (en[2]) sum <= psum[0] + psum[1] + psum[2];
    if (en[3]) mag <= MagW'(sum[SumW-1] ? -sum : sum);
    if (en[4]) scaled <= ScW'(mag) * ScW'(gain);
    // saturate at 1.0
    if (en[5]) idx <= (raw > RawW'(IdxOne)) ? IdxOne : IdxW'(raw);
  end

  // low indices take the linear segment, looked up directly
  always_ff @(posedge clk) begin
    if (en[MAC_STAGES]) begin
      lin_q[0]  <= idx < IdxW'(LinLimit);
      linb_q[0] <= Lin[idx[LIN_TAB_BITS-1:0]];
    end
    for (int j = 1; j < SRCH_STEPS; j++) begin
      if (en[MAC_STAGES+j]) begin
        lin_q[j]  <= lin_q[j-1];
        linb_q[j] <= linb_q[j-1];
      end
    end
  end

  // one result bit per stage, msb first: largest byte whose threshold <= idx
  for (genvar j = 0; j < SRCH_STEPS; j++) begin : g_srch
    logic [BYTE_BITS-1:0] acc_in;
    logic [BYTE_BITS-1:0] cand;
    logic [IdxW-1:0]      idx_in;
    logic                 take;

    if (j == 0) begin : g_first
      assign acc_in = '0;
      assign idx_in = idx;
    end else begin : g_rest
      assign acc_in = acc_q[j-1];
      assign idx_in = sidx_q[j-1];
    end

    assign cand = acc_in | (BYTE_BITS'(1) << (SRCH_STEPS - 1 - j));
    assign take = Thr[cand][LUT_INDEX_BITS:0] <= idx_in;

    always_ff @(posedge clk) begin
      if (en[MAC_STAGES+j]) begin
        acc_q[j]  <= take ? cand : acc_in;
        sidx_q[j] <= idx_in;
      end
    end
  end

  assign code = lin_q[SRCH_STEPS-1] ? linb_q[SRCH_STEPS-1] : acc_q[SRCH_STEPS-1];

endmodule

FILE: sv/mbs_merge.sv
// output stage: joins the three channel bytes with the validity verdict and
// substitutes magenta for bad pixels in every mode but keep; uses mbs_pkg
module mbs_merge import mbs_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [MODE_BITS-1:0] mode,
  input  pix_rgb_t             raw,
  output pix_rgb_t             pix
);

  always_ff @(posedge clk) begin
    if (en) begin
      if (raw.bad && (mode != MODE_KEEP)) begin
        pix.red   <= BYTE_FULL;
        pix.green <= '0;
        pix.blue  <= BYTE_FULL;
        pix.bad   <= 1'b1;
      end else begin
        pix <= raw;
      end
    end
  end

endmodule

FILE: sv/multiband_to_srgb_pixel_unit.sv
// top level of the multiband to srgb pixel unit: config registers, pipeline
// flow control, three color lanes, the check unit and the output merge
// depends on mbs_pkg, mbs_lane, mbs_check, mbs_merge

// Takes one pixel of six spectral band samples per beat and returns one sRGB
// pixel per beat, one pixel per clock sustained while pixel_stall is low. A
// pixel passes six stages of band mixing, magnitude, gain and index, eight
// stages of threshold search for the sRGB byte (one result bit each), and
// the output register. Every stage holds its own valid bit and fills whenever
// it is empty or its successor moves, so bubbles close up and new pixels keep
// entering while a finished pixel waits on pixel_stall.
// Registers (byte address 0: bad_pixel_mode, 4: linear_gain) may only be
// written while the pipeline is empty. No clearing pass after reset.
module multiband_to_srgb_pixel_unit import mbs_pkg::*; #(
  parameter int SAMPLE_BITS    = SAMPLE_BITS_DEF,
  parameter int LUT_INDEX_BITS = LUT_INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [PADDR_BITS-1:0]         paddr,
  input  logic [DATA_BITS-1:0]          pwdata,
  output logic [DATA_BITS-1:0]          prdata,
  output logic                          pready,
  input  logic                          band_valid,
  output logic                          band_stall,
  input  logic signed [SAMPLE_BITS-1:0] band_360,
  input  logic signed [SAMPLE_BITS-1:0] band_415,
  input  logic signed [SAMPLE_BITS-1:0] band_566,
  input  logic signed [SAMPLE_BITS-1:0] band_604,
  input  logic signed [SAMPLE_BITS-1:0] band_643,
  input  logic signed [SAMPLE_BITS-1:0] band_689,
  input  logic [MASK_BITS-1:0]          nonfinite_mask,
  output logic                          pixel_valid,
  input  logic                          pixel_stall,
  output logic [BYTE_BITS-1:0]          red_out,
  output logic [BYTE_BITS-1:0]          green_out,
  output logic [BYTE_BITS-1:0]          blue_out,
  output logic                          pixel_bad
);

  logic [MODE_BITS-1:0]          bad_pixel_mode;
  logic [GAIN_BITS-1:0]          linear_gain;
  logic                          cfg_wr;
  reg_sel_t                      reg_sel;
  logic [PIPE_STAGES-1:0]        vq;
  logic [PIPE_STAGES-1:0]        vq_next;
  logic [PIPE_STAGES-1:0]        rdy;
  logic signed [SAMPLE_BITS-1:0] band [NUM_BANDS];
  logic [NUM_BANDS-1:0]          keep;
  logic [BYTE_BITS-1:0]          code [NUM_CH];
  logic                          lane_bad;
  pix_rgb_t                      raw;
  pix_rgb_t                      pix;

  // config port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_sel_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      bad_pixel_mode <= MODE_KEEP;
      linear_gain    <= GAIN_RESET;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_MODE: bad_pixel_mode <= pwdata[MODE_BITS-1:0];
        REG_GAIN: linear_gain    <= pwdata[GAIN_BITS-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_MODE: prdata = DATA_BITS'(bad_pixel_mode);
      REG_GAIN: prdata = DATA_BITS'(linear_gain);
      default:  prdata = '0;
    endcase
  end

  // a stage moves when it or any stage after it is empty, or the output drains
  for (genvar i = 0; i < PIPE_STAGES; i++) begin : g_rdy
    assign rdy[i] = !pixel_stall || !(&vq[PIPE_STAGES-1:i]);
  end

  assign vq_next = (vq & ~rdy) | ({vq[PIPE_STAGES-2:0], band_valid} & rdy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vq <= '0;
    end else begin
      vq <= vq_next;
    end
  end

  assign band_stall  = !rdy[0];
  assign pixel_valid = vq[PIPE_STAGES-1];

  always_comb begin
    band[0] = band_360;
    band[1] = band_415;
    band[2] = band_566;
    band[3] = band_604;
    band[4] = band_643;
    band[5] = band_689;
  end

  mbs_check #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_check (
    .clk  (clk),
    .en   (rdy[LANE_STAGES-1:0]),
    .band (band),
    .mask (nonfinite_mask),
    .keep (keep),
    .bad  (lane_bad)
  );

  for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
    mbs_lane #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .LUT_INDEX_BITS (LUT_INDEX_BITS),
      .CH             (c)
    ) u_lane (
      .clk  (clk),
      .en   (rdy[LANE_STAGES-1:0]),
      .band (band),
      .keep (keep),
      .gain (linear_gain),
      .code (code[c])
    );
  end

  assign raw.red   = code[0];
  assign raw.green = code[1];
  assign raw.blue  = code[2];
  assign raw.bad   = lane_bad;

  mbs_merge u_merge (
    .clk  (clk),
    .en   (rdy[PIPE_STAGES-1]),
    .mode (bad_pixel_mode),
    .raw  (raw),
    .pix  (pix)
  );

  assign red_out   = pix.red;
  assign green_out = pix.green;
  assign blue_out  = pix.blue;
  assign pixel_bad = pix.bad;

  // an accepted beat always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    band_valid && !band_stall |=> vq[0])
    else $error("accepted beat did not enter the pipeline");

  // an empty output register keeps the whole pipe moving
  a_empty_out_flows: assert property (@(posedge clk) disable iff (rst)
    !vq[PIPE_STAGES-1] |-> !band_stall)
    else $error("input stalled with an empty output register");

  // a new output beat only comes from a valid last lane stage
  a_out_from_lane: assert property (@(posedge clk) disable iff (rst)
    $rose(pixel_valid) |-> $past(vq[PIPE_STAGES-2]))
    else $error("output valid rose without a pixel behind it");

  // gain write is visible on the next cycle
  a_gain_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr && (reg_sel == REG_GAIN) |=> linear_gain == $past(pwdata[GAIN_BITS-1:0]))
    else $error("gain register write lost");

endmodule
